FILE: rtl/ppae_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppae_pkg
// Shared constants, codes and types of the packed pixel access engine.
// ----------------------------------------------------------------------------
package ppae_pkg;

  localparam int unsigned STORE_BYTES = 65536;
  localparam int unsigned AW          = $clog2(STORE_BYTES);
  localparam int unsigned BANK_AW     = AW - 2;
  localparam int unsigned PAL_ENTRIES = 256;

  localparam logic [2:0] FMT_1BPP  = 3'd0;
  localparam logic [2:0] FMT_4BPP  = 3'd1;
  localparam logic [2:0] FMT_8BPP  = 3'd2;
  localparam logic [2:0] FMT_16BPP = 3'd3;
  localparam logic [2:0] FMT_24BPP = 3'd4;
  localparam logic [2:0] FMT_32RAW = 3'd5;
  localparam logic [2:0] FMT_32BF  = 3'd6;
  localparam logic [2:0] FMT_NONE  = 3'd7;

  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_PAL   = 2'd2;
  localparam logic [1:0] CMD_NONE  = 2'd3;

  localparam logic [2:0] REG_FORMAT  = 3'd0;
  localparam logic [2:0] REG_STRIDE  = 3'd1;
  localparam logic [2:0] REG_RSHIFT  = 3'd2;
  localparam logic [2:0] REG_RLEN    = 3'd3;
  localparam logic [2:0] REG_GSHIFT  = 3'd4;
  localparam logic [2:0] REG_GLEN    = 3'd5;
  localparam logic [2:0] REG_BSHIFT  = 3'd6;
  localparam logic [2:0] REG_BLEN    = 3'd7;

  typedef enum logic [1:0] {K_READ, K_WRITE, K_PAL, K_NOP} kind_e;

  typedef struct packed {
    logic [2:0]  fmt;
    logic [15:0] stride;
    logic [4:0]  r_shift;
    logic [5:0]  r_len;
    logic [4:0]  g_shift;
    logic [5:0]  g_len;
    logic [4:0]  b_shift;
    logic [5:0]  b_len;
  } cfg_t;

  typedef struct packed {
    kind_e        kind;
    logic         oor;
    logic [AW-1:0] addr;
    logic [2:0]   xlo;
    logic [31:0]  am;
    logic [31:0]  xm;
    logic [7:0]   pidx;
    logic [23:0]  pcol;
  } q_entry_t;

endpackage

FILE: rtl/packed_pixel_access_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packed_pixel_access_engine
// Packed pixel read and AND/XOR write over a byte frame store with a palette.
// ----------------------------------------------------------------------------
// Channel  | Dir | Payload
// s_axis   | in  | tdata: cmd, x, y, and_mask, xor_mask, pal_index, pal_color
// m_axis   | out | tdata: pixel_value; tuser: out_of_range
// apb      | in  | eight registers at 4*i
// Front steps: capture, y*stride multiply, address add; one command at a time.
// Back steps: queue pop, one bank read, write or palette read.
// Frame store is four byte banks, so all bytes of an unaligned word are read together.
// Reset clears control and sets configuration to defaults; stores are undefined.
// A stalled m_axis holds the back; the queue lets the front run on.
module packed_pixel_access_engine (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // cmd[1:0], x[17:2], y[33:18], and_mask[65:34], xor_mask[97:66],
  // pal_index[105:98], pal_color[129:106]
  input  logic [135:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // pixel_value[31:0]
  output logic [31:0]  m_axis_tdata,
  // out_of_range[0]
  output logic         m_axis_tuser,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  ppae_pkg::cfg_t     cfg_q;
  ppae_pkg::q_entry_t fe_entry, q_head;
  logic               push, full, pop, empty;
  logic               wr;
  logic [2:0]         ridx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign ridx   = paddr[4:2];

  always_comb begin
    case (ridx)
      ppae_pkg::REG_FORMAT: prdata = 32'(cfg_q.fmt);
      ppae_pkg::REG_STRIDE: prdata = 32'(cfg_q.stride);
      ppae_pkg::REG_RSHIFT: prdata = 32'(cfg_q.r_shift);
      ppae_pkg::REG_RLEN:   prdata = 32'(cfg_q.r_len);
      ppae_pkg::REG_GSHIFT: prdata = 32'(cfg_q.g_shift);
      ppae_pkg::REG_GLEN:   prdata = 32'(cfg_q.g_len);
      ppae_pkg::REG_BSHIFT: prdata = 32'(cfg_q.b_shift);
      default:              prdata = 32'(cfg_q.b_len);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fmt     <= ppae_pkg::FMT_32RAW;
      cfg_q.stride  <= 16'd0;
      cfg_q.r_shift <= 5'd16;
      cfg_q.r_len   <= 6'd8;
      cfg_q.g_shift <= 5'd8;
      cfg_q.g_len   <= 6'd8;
      cfg_q.b_shift <= 5'd0;
      cfg_q.b_len   <= 6'd8;
    end else if (wr) begin
      case (ridx)
        ppae_pkg::REG_FORMAT: cfg_q.fmt     <= pwdata[2:0];
        ppae_pkg::REG_STRIDE: cfg_q.stride  <= pwdata[15:0];
        ppae_pkg::REG_RSHIFT: cfg_q.r_shift <= pwdata[4:0];
        ppae_pkg::REG_RLEN:   cfg_q.r_len   <= pwdata[5:0];
        ppae_pkg::REG_GSHIFT: cfg_q.g_shift <= pwdata[4:0];
        ppae_pkg::REG_GLEN:   cfg_q.g_len   <= pwdata[5:0];
        ppae_pkg::REG_BSHIFT: cfg_q.b_shift <= pwdata[4:0];
        default:              cfg_q.b_len   <= pwdata[5:0];
      endcase
    end
  end

  ppae_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .cmd_i      (s_axis_tdata[1:0]),
    .x_i        (s_axis_tdata[17:2]),
    .y_i        (s_axis_tdata[33:18]),
    .am_i       (s_axis_tdata[65:34]),
    .xm_i       (s_axis_tdata[97:66]),
    .pidx_i     (s_axis_tdata[105:98]),
    .pcol_i     (s_axis_tdata[129:106]),
    .push_o     (push),
    .entry_o    (fe_entry),
    .full_i     (full)
  );

  ppae_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (fe_entry),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (q_head)
  );

  ppae_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .empty_i     (empty),
    .head_i      (q_head),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .pixel_o     (m_axis_tdata),
    .oor_o       (m_axis_tuser)
  );

endmodule

FILE: rtl/ppae_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppae_front
// Accept a command, compute its byte address and range, classify it.
// ----------------------------------------------------------------------------
module ppae_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ppae_pkg::cfg_t    cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        cmd_i,
  input  logic [15:0]       x_i,
  input  logic [15:0]       y_i,
  input  logic [31:0]       am_i,
  input  logic [31:0]       xm_i,
  input  logic [7:0]        pidx_i,
  input  logic [23:0]       pcol_i,
  output logic              push_o,
  output ppae_pkg::q_entry_t entry_o,
  input  logic              full_i
);

  logic        s1_q, s1_d, s2_q, s2_d;
  logic [1:0]  cmd_q;
  logic [15:0] x_q, y_q;
  logic [31:0] am_q, xm_q, prod_q;
  logic [7:0]  pidx_q;
  logic [23:0] pcol_q;
  logic [17:0] off;
  logic [2:0]  nb;
  logic [32:0] addr;
  logic        accept;

  assign in_ready_o = !s1_q && !s2_q;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = s2_q && !full_i;

  always_comb begin
    case (cfg_i.fmt)
      ppae_pkg::FMT_1BPP:  begin off = 18'(x_q >> 3); nb = 3'd1; end
      ppae_pkg::FMT_4BPP:  begin off = 18'(x_q >> 1); nb = 3'd1; end
      ppae_pkg::FMT_8BPP:  begin off = 18'(x_q);      nb = 3'd1; end
      ppae_pkg::FMT_16BPP: begin off = {1'b0, x_q, 1'b0}; nb = 3'd2; end
      ppae_pkg::FMT_24BPP: begin off = 18'(x_q) + {1'b0, x_q, 1'b0}; nb = 3'd3; end
      default:             begin off = {x_q, 2'b00}; nb = 3'd4; end
    endcase
    addr = {1'b0, prod_q} + 33'(off);
    entry_o.oor  = (addr + 33'(nb)) > 33'(ppae_pkg::STORE_BYTES);
    entry_o.addr = addr[ppae_pkg::AW-1:0];
    entry_o.xlo  = x_q[2:0];
    entry_o.am   = am_q;
    entry_o.xm   = xm_q;
    entry_o.pidx = pidx_q;
    entry_o.pcol = pcol_q;
    case (cmd_q)
      ppae_pkg::CMD_READ:
        entry_o.kind = (cfg_i.fmt == ppae_pkg::FMT_NONE) ? ppae_pkg::K_NOP : ppae_pkg::K_READ;
      ppae_pkg::CMD_WRITE:
        entry_o.kind = (cfg_i.fmt == ppae_pkg::FMT_NONE) ? ppae_pkg::K_NOP : ppae_pkg::K_WRITE;
      ppae_pkg::CMD_PAL:   entry_o.kind = ppae_pkg::K_PAL;
      default:             entry_o.kind = ppae_pkg::K_NOP;
    endcase
    s1_d = accept;
    s2_d = s1_q || (s2_q && full_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= 1'b0;
      s2_q <= 1'b0;
    end else begin
      s1_q <= s1_d;
      s2_q <= s2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= cmd_i;
      x_q    <= x_i;
      y_q    <= y_i;
      am_q   <= am_i;
      xm_q   <= xm_i;
      pidx_q <= pidx_i;
      pcol_q <= pcol_i;
    end
    if (s1_q) prod_q <= y_q * cfg_i.stride;
  end

endmodule

FILE: rtl/ppae_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppae_queue
// Two-entry queue between front and back.
// ----------------------------------------------------------------------------
module ppae_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  ppae_pkg::q_entry_t data_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               empty_o,
  output ppae_pkg::q_entry_t data_o
);

  ppae_pkg::q_entry_t mem_q [2];
  logic       wp_q, wp_d, rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign data_o  = mem_q[rp_q];

  always_comb begin
    wp_d  = wp_q ^ push_i;
    rp_d  = rp_q ^ pop_i;
    cnt_d = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

endmodule

FILE: rtl/ppae_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppae_back
// Carry out reads and read-modify-writes on four byte banks, and palette loads.
// ----------------------------------------------------------------------------
module ppae_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ppae_pkg::cfg_t     cfg_i,
  input  logic               empty_i,
  input  ppae_pkg::q_entry_t head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [31:0]        pixel_o,
  output logic               oor_o
);

  typedef enum logic [2:0] {B_IDLE, B_RD, B_ACC, B_PAL, B_OUT} state_e;

  state_e                     state_q;
  ppae_pkg::q_entry_t         cur_q;
  logic [7:0]                 bank_mem [4][2**ppae_pkg::BANK_AW];
  logic [7:0]                 rd_q [4];
  logic [23:0]                pal_mem [ppae_pkg::PAL_ENTRIES];
  logic [23:0]                pal_rd_q;
  logic                       pal_hit_q;
  logic [31:0]                res_q;
  logic                       res_oor_q;
  logic                       out_valid_q;
  logic [31:0]                pixel_q;
  logic                       oor_q;
  logic [ppae_pkg::BANK_AW-1:0] baddr [4];
  logic [7:0]                 obyte [4];
  logic [7:0]                 nbyte [4];
  logic [3:0]                 bwe;
  logic [7:0]                 wbyte [4];
  logic [31:0]                word;
  logic [7:0]                 pix_idx;
  logic [31:0]                direct;
  logic [2:0]                 nb;
  logic [7:0]                 m1, ba, bx;
  logic                       slot;

  function automatic logic [7:0] take_field(logic [31:0] w, logic [4:0] sh, logic [5:0] len);
    logic [31:0] mask;
    logic [63:0] wide;
    logic [6:0]  top;
    mask = (len >= 6'd32) ? 32'hffff_ffff : 32'(((33'd1 << len) - 33'd1) << sh);
    top  = 7'(sh) + 7'(len);
    wide = {w & mask, 32'd0} >> top;
    return (top >= 7'd64) ? 8'd0 : wide[31:24];
  endfunction

  assign slot        = !out_valid_q || out_ready_i;
  assign pop_o       = (state_q == B_IDLE) && !empty_i;
  assign out_valid_o = out_valid_q;
  assign pixel_o     = pixel_q;
  assign oor_o       = oor_q;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      baddr[k] = cur_q.addr[ppae_pkg::AW-1:2]
               + ppae_pkg::BANK_AW'(2'(k) < cur_q.addr[1:0]);
      obyte[k] = rd_q[2'(2'(k) + cur_q.addr[1:0])];
    end
    word = {obyte[3], obyte[2], obyte[1], obyte[0]};
    case (cfg_i.fmt)
      ppae_pkg::FMT_1BPP:  pix_idx = {7'd0, obyte[0][3'd7 - cur_q.xlo]};
      ppae_pkg::FMT_4BPP:  pix_idx = cur_q.xlo[0] ? {4'd0, obyte[0][3:0]} : {4'd0, obyte[0][7:4]};
      default:             pix_idx = obyte[0];
    endcase
    case (cfg_i.fmt)
      ppae_pkg::FMT_16BPP: direct = {8'd0, word[14:10], 3'd0, word[9:5], 3'd0, word[4:0], 3'd0};
      ppae_pkg::FMT_24BPP: direct = {8'd0, obyte[0], obyte[1], obyte[2]};
      ppae_pkg::FMT_32RAW: direct = word;
      default: direct = {8'd0, take_field(word, cfg_i.r_shift, cfg_i.r_len),
                         take_field(word, cfg_i.g_shift, cfg_i.g_len),
                         take_field(word, cfg_i.b_shift, cfg_i.b_len)};
    endcase
    case (cfg_i.fmt)
      ppae_pkg::FMT_1BPP, ppae_pkg::FMT_4BPP, ppae_pkg::FMT_8BPP: nb = 3'd1;
      ppae_pkg::FMT_16BPP: nb = 3'd2;
      ppae_pkg::FMT_24BPP: nb = 3'd3;
      default:             nb = 3'd4;
    endcase
    m1 = 8'h80 >> cur_q.xlo;
    case (cfg_i.fmt)
      ppae_pkg::FMT_1BPP: begin
        ba = {8{cur_q.am[0]}} | ~m1;
        bx = {8{cur_q.xm[0]}} & m1;
      end
      ppae_pkg::FMT_4BPP: begin
        ba = cur_q.xlo[0] ? {4'hf, cur_q.am[3:0]} : {cur_q.am[3:0], 4'hf};
        bx = cur_q.xlo[0] ? {4'h0, cur_q.xm[3:0]} : {cur_q.xm[3:0], 4'h0};
      end
      default: begin
        ba = cur_q.am[7:0];
        bx = cur_q.xm[7:0];
      end
    endcase
    for (int i = 0; i < 4; i++) begin
      nbyte[i] = (i == 0) ? ((obyte[0] & ba) ^ bx)
                          : ((obyte[i] & cur_q.am[8*i +: 8]) ^ cur_q.xm[8*i +: 8]);
    end
    for (int k = 0; k < 4; k++) begin
      bwe[k]   = (state_q == B_ACC) && (cur_q.kind == ppae_pkg::K_WRITE)
               && (3'(2'(2'(k) - cur_q.addr[1:0])) < nb);
      wbyte[k] = nbyte[2'(2'(k) - cur_q.addr[1:0])];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 4; k++) begin
      if (state_q == B_RD) rd_q[k] <= bank_mem[k][baddr[k]];
      if (bwe[k]) bank_mem[k][baddr[k]] <= wbyte[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && head_i.kind == ppae_pkg::K_PAL && 32'(head_i.pidx) < ppae_pkg::PAL_ENTRIES)
      pal_mem[head_i.pidx] <= head_i.pcol;
    if (state_q == B_ACC) begin
      pal_rd_q  <= pal_mem[pix_idx];
      pal_hit_q <= 32'(pix_idx) < ppae_pkg::PAL_ENTRIES;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
      cur_q       <= '0;
      res_q       <= '0;
      res_oor_q   <= 1'b0;
      pixel_q     <= '0;
      oor_q       <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && state_q != B_OUT) out_valid_q <= 1'b0;
      case (state_q)
        B_IDLE: begin
          if (!empty_i) begin
            cur_q     <= head_i;
            res_q     <= '0;
            res_oor_q <= head_i.oor && (head_i.kind == ppae_pkg::K_READ
                                     || head_i.kind == ppae_pkg::K_WRITE);
            if ((head_i.kind == ppae_pkg::K_READ || head_i.kind == ppae_pkg::K_WRITE)
                && !head_i.oor) begin
              state_q <= B_RD;
            end else begin
              state_q <= B_OUT;
            end
          end
        end
        B_RD: state_q <= B_ACC;
        B_ACC: begin
          if (cur_q.kind == ppae_pkg::K_READ && (cfg_i.fmt == ppae_pkg::FMT_1BPP
              || cfg_i.fmt == ppae_pkg::FMT_4BPP || cfg_i.fmt == ppae_pkg::FMT_8BPP)) begin
            state_q <= B_PAL;
          end else begin
            if (cur_q.kind == ppae_pkg::K_READ) res_q <= direct;
            state_q <= B_OUT;
          end
        end
        B_PAL: begin
          res_q   <= pal_hit_q ? {8'd0, pal_rd_q} : 32'd0;
          state_q <= B_OUT;
        end
        B_OUT: begin
          if (slot) begin
            out_valid_q <= 1'b1;
            pixel_q     <= res_q;
            oor_q       <= res_oor_q;
            state_q     <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

endmodule
